>>> src/ibmw_pkg.sv
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared widths, codes and item types of the inode block map walker.
// ----------------------------------------------------------------------------
package ibmw_pkg;

  localparam int DIRECT_POINTERS_DEF = 12;
  localparam int INDIRECT_ROOTS      = 3;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 48;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 17;
  localparam int LOG_W    = 3;
  localparam int LEVEL_W  = 2;
  localparam int REG_IDX_W = 1;

  localparam int BASE_LOG      = 10;
  localparam int MAX_SIZE_LOG  = 6;
  localparam int PTR_BYTES_LOG = 2;
  localparam int SHIFT_W       = 5;
  localparam int WORD_IDX_W    = BASE_LOG + MAX_SIZE_LOG - PTR_BYTES_LOG;
  localparam int CAP_W         = 3 * WORD_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE_LOG = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FILE_SIZE      = 1'b1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPLY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HOLE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EOF    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_ANSWER  = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_IDLE = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO  = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] block_index;
  } item_t;

  typedef struct packed {
    logic                kind;
    logic [ADDR_W-1:0]   read_address;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   physical_block;
    logic [LEN_W-1:0]    read_length;
  } result_t;

endpackage

>>> src/ibmw_if.sv
// ----------------------------------------------------------------------------
// ibmw_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ibmw_in_if;
  import ibmw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] value;
  logic [WORD_W-1:0] block_index;

  modport source(output valid, cmd, slot, value, block_index, input ready);
  modport sink(input valid, cmd, slot, value, block_index, output ready);
endinterface

interface ibmw_out_if;
  import ibmw_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [ADDR_W-1:0]   read_address;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   physical_block;
  logic [LEN_W-1:0]    read_length;

  modport source(output valid, kind, read_address, status, physical_block, read_length,
                 input ready);
  modport sink(input valid, kind, read_address, status, physical_block, read_length,
               output ready);
endinterface

>>> src/ibmw_in_reg.sv
// ----------------------------------------------------------------------------
// ibmw_in_reg
// Input register: holds one transaction until the walk stage takes it.
// ----------------------------------------------------------------------------
module ibmw_in_reg (
  input  logic            clk,
  input  logic            rst,
  ibmw_in_if.sink         item,
  input  logic            take,
  output logic            valid,
  output ibmw_pkg::item_t data
);
  import ibmw_pkg::*;

  logic accept;

  assign item.ready = !valid || take;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data.cmd         <= item.cmd;
      data.slot        <= item.slot;
      data.value       <= item.value;
      data.block_index <= item.block_index;
    end
  end

endmodule

>>> src/ibmw_ptr_table.sv
// ----------------------------------------------------------------------------
// ibmw_ptr_table
// Inode pointer table: direct pointers then single, double, triple roots.
// ----------------------------------------------------------------------------
module ibmw_ptr_table #(
  parameter int DEPTH = ibmw_pkg::DIRECT_POINTERS_DEF + ibmw_pkg::INDIRECT_ROOTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ibmw_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [ibmw_pkg::WORD_W-1:0] rd_data
);
  import ibmw_pkg::*;

  logic [WORD_W-1:0] ptrs [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        ptrs[i] <= '0;
      end
    end else if (wr_en) begin
      ptrs[wr_addr] <= wr_data;
    end
  end

  assign rd_data = (32'(rd_addr) < 32'(DEPTH)) ? ptrs[rd_addr] : '0;

endmodule

>>> src/ibmw_walk.sv
// ----------------------------------------------------------------------------
// ibmw_walk
// Lookup and indirect walk logic, walk state and the result register.
// ----------------------------------------------------------------------------
module ibmw_walk #(
  parameter int DIRECT_POINTERS = ibmw_pkg::DIRECT_POINTERS_DEF,
  parameter int DEPTH           = DIRECT_POINTERS + ibmw_pkg::INDIRECT_ROOTS,
  parameter int AW              = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  ibmw_pkg::item_t             item,
  output logic                        take,
  input  logic [ibmw_pkg::LOG_W-1:0]  block_size_log,
  input  logic [ibmw_pkg::WORD_W-1:0] file_size,
  output logic                        tbl_wr_en,
  output logic [AW-1:0]               tbl_wr_addr,
  output logic [AW-1:0]               tbl_rd_addr,
  input  logic [ibmw_pkg::WORD_W-1:0] tbl_rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ibmw_pkg::result_t           out_data
);
  import ibmw_pkg::*;

  logic [LEVEL_W-1:0] walk_level, walk_level_next;
  logic [WORD_W-1:0]  remaining_offset, remaining_offset_next;
  logic [LEN_W-1:0]   pending_length, pending_length_next;

  logic [LOG_W-1:0]   size_log;
  logic [SHIFT_W-1:0] blk_shift;
  logic [3:0]         words_log;
  logic [4:0]         words_log2;
  logic [5:0]         words_log3;
  logic [LEN_W-1:0]   block_bytes;
  logic [ADDR_W-1:0]  start;
  logic               eof;
  logic [WORD_W-1:0]  rest;
  logic [LEN_W-1:0]   pend;
  logic               direct;
  logic [WORD_W-1:0]  off;
  logic [CAP_W-1:0]   lim1, lim2, lim3;
  logic [CAP_W-1:0]   off_wide;
  logic [LEVEL_W-1:0] lvl;
  logic [WORD_W-1:0]  off_lvl;
  logic               over_range;

  logic [WORD_W-1:0]     req_ptr;
  logic [LEVEL_W-1:0]    req_lvl;
  logic [WORD_W-1:0]     req_off;
  logic [SHIFT_W-1:0]    req_shift;
  logic [WORD_IDX_W-1:0] req_word;
  logic [WORD_W-1:0]     req_rem;
  logic [ADDR_W-1:0]     req_addr;

  logic    has_result;
  result_t res;

  assign take = item_valid && (!out_valid || out_ready);

  // block geometry
  assign size_log    = (block_size_log > LOG_W'(MAX_SIZE_LOG)) ? LOG_W'(MAX_SIZE_LOG)
                                                                : block_size_log;
  assign blk_shift   = SHIFT_W'(BASE_LOG) + SHIFT_W'(size_log);
  assign words_log   = 4'(BASE_LOG - PTR_BYTES_LOG) + 4'(size_log);
  assign words_log2  = {words_log, 1'b0};
  assign words_log3  = 6'(words_log) + 6'(words_log2);
  assign block_bytes = LEN_W'(1) << blk_shift;

  // end of file and reported length
  assign start = ADDR_W'(item.block_index) << blk_shift;
  assign eof   = start >= ADDR_W'(file_size);
  assign rest  = file_size - start[WORD_W-1:0];
  assign pend  = (rest < WORD_W'(block_bytes)) ? rest[LEN_W-1:0] : block_bytes;

  // indirect level
  assign direct   = item.block_index < WORD_W'(DIRECT_POINTERS);
  assign off      = item.block_index - WORD_W'(DIRECT_POINTERS);
  assign off_wide = CAP_W'(off);
  assign lim1     = CAP_W'(1) << words_log;
  assign lim2     = lim1 + (CAP_W'(1) << words_log2);
  assign lim3     = lim2 + (CAP_W'(1) << words_log3);

  always_comb begin
    over_range = 1'b0;
    lvl        = LEVEL_ONE;
    off_lvl    = off;
    if (off_wide < lim1) begin
      lvl     = LEVEL_ONE;
      off_lvl = off;
    end else if (off_wide < lim2) begin
      lvl     = LEVEL_TWO;
      off_lvl = off - lim1[WORD_W-1:0];
    end else if (off_wide < lim3) begin
      lvl     = LEVEL_THREE;
      off_lvl = off - lim2[WORD_W-1:0];
    end else begin
      over_range = 1'b1;
    end
  end

  assign tbl_rd_addr = direct ? AW'(item.block_index)
                              : AW'(DIRECT_POINTERS - 1) + AW'(lvl);
  assign tbl_wr_addr = AW'(item.slot);
  assign tbl_wr_en   = take && (item.cmd == CMD_LOAD)
                       && (32'(item.slot) < 32'(DEPTH));

  // pointer word request
  assign req_ptr = (item.cmd == CMD_REPLY) ? item.value : tbl_rd_data;
  assign req_lvl = (item.cmd == CMD_REPLY) ? walk_level - LEVEL_ONE : lvl;
  assign req_off = (item.cmd == CMD_REPLY) ? remaining_offset : off_lvl;

  always_comb begin
    case (req_lvl)
      LEVEL_TWO:   req_shift = SHIFT_W'(words_log);
      LEVEL_THREE: req_shift = words_log2;
      default:     req_shift = '0;
    endcase
  end

  assign req_word = WORD_IDX_W'(req_off >> req_shift);
  assign req_rem  = req_off & ((WORD_W'(1) << req_shift) - WORD_W'(1));
  assign req_addr = (ADDR_W'(req_ptr) << blk_shift)
                    | ADDR_W'({req_word, {PTR_BYTES_LOG{1'b0}}});

  always_comb begin
    has_result            = 1'b0;
    res                   = '0;
    walk_level_next       = walk_level;
    remaining_offset_next = remaining_offset;
    pending_length_next   = pending_length;
    case (item.cmd)
      CMD_LOOKUP: begin
        if (walk_level == LEVEL_IDLE) begin
          has_result = 1'b1;
          res.kind   = KIND_ANSWER;
          if (eof) begin
            res.status = ST_EOF;
          end else begin
            pending_length_next = pend;
            if (direct) begin
              if (tbl_rd_data == '0) begin
                res.status      = ST_HOLE;
                res.read_length = block_bytes;
              end else begin
                res.status         = ST_MAPPED;
                res.physical_block = tbl_rd_data;
                res.read_length    = pend;
              end
            end else if (over_range) begin
              res.status = ST_RANGE;
            end else if (tbl_rd_data == '0) begin
              res.status      = ST_HOLE;
              res.read_length = block_bytes;
            end else begin
              res.kind              = KIND_REQUEST;
              res.read_address      = req_addr;
              walk_level_next       = req_lvl;
              remaining_offset_next = req_rem;
            end
          end
        end
      end
      CMD_REPLY: begin
        if (walk_level != LEVEL_IDLE) begin
          has_result      = 1'b1;
          res.kind        = KIND_ANSWER;
          walk_level_next = LEVEL_IDLE;
          if (item.value == '0) begin
            res.status      = ST_HOLE;
            res.read_length = block_bytes;
          end else if (walk_level == LEVEL_ONE) begin
            res.status         = ST_MAPPED;
            res.physical_block = item.value;
            res.read_length    = pending_length;
          end else begin
            res.kind              = KIND_REQUEST;
            res.read_address      = req_addr;
            walk_level_next       = req_lvl;
            remaining_offset_next = req_rem;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_level       <= LEVEL_IDLE;
      remaining_offset <= '0;
      pending_length   <= '0;
    end else if (take) begin
      walk_level       <= walk_level_next;
      remaining_offset <= remaining_offset_next;
      pending_length   <= pending_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      out_data <= res;
    end
  end

endmodule

>>> src/inode_block_map_walker.sv
// ----------------------------------------------------------------------------
// inode_block_map_walker
// Maps a logical file block onto a physical block through an inode's direct
// and indirect pointers, issuing one pointer-word read per indirect level.
// ----------------------------------------------------------------------------
// Each transaction passes through an input register and one stage of logic
// into a result register, so the block takes one transaction per clock while
// the result channel does not stall; each result is registered when the walk
// stage takes its transaction from the input register. The pointer table read,
// the end-of-file compare and the level search all sit in that one stage. A
// lookup that walks the indirect tree answers only after one read reply per
// level. Configuration must be written only while no transaction is in flight;
// it is not enforced. The pointer table clears at reset with no clearing pass.
module inode_block_map_walker #(
  parameter int DIRECT_POINTERS = ibmw_pkg::DIRECT_POINTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [ibmw_pkg::WORD_W-1:0] cfg_data,
  ibmw_in_if.sink                     item,
  ibmw_out_if.source                  result
);
  import ibmw_pkg::*;

  localparam int DEPTH = DIRECT_POINTERS + INDIRECT_ROOTS;
  localparam int AW    = $clog2(DEPTH);

  logic [LOG_W-1:0]  block_size_log;
  logic [WORD_W-1:0] file_size;

  logic              stage_valid;
  item_t             stage_item;
  logic              take;
  logic              tbl_wr_en;
  logic [AW-1:0]     tbl_wr_addr;
  logic [AW-1:0]     tbl_rd_addr;
  logic [WORD_W-1:0] tbl_rd_data;
  result_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log <= '0;
      file_size      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_SIZE_LOG: block_size_log <= cfg_data[LOG_W-1:0];
        REG_FILE_SIZE:      file_size      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ibmw_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .take  (take),
    .valid (stage_valid),
    .data  (stage_item)
  );

  ibmw_ptr_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ptr_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (stage_item.value),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  ibmw_walk #(
    .DIRECT_POINTERS (DIRECT_POINTERS),
    .DEPTH           (DEPTH),
    .AW              (AW)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (stage_valid),
    .item           (stage_item),
    .take           (take),
    .block_size_log (block_size_log),
    .file_size      (file_size),
    .tbl_wr_en      (tbl_wr_en),
    .tbl_wr_addr    (tbl_wr_addr),
    .tbl_rd_addr    (tbl_rd_addr),
    .tbl_rd_data    (tbl_rd_data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_data       (res)
  );

  assign result.kind           = res.kind;
  assign result.read_address   = res.read_address;
  assign result.status         = res.status;
  assign result.physical_block = res.physical_block;
  assign result.read_length    = res.read_length;

endmodule

>>> src/ibmw_checker.sv
// ----------------------------------------------------------------------------
// ibmw_checker
// Port-level checks on the result channel of the block map walker.
// ----------------------------------------------------------------------------
module ibmw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          kind,
  input logic [ibmw_pkg::ADDR_W-1:0]   read_address,
  input logic [ibmw_pkg::STATUS_W-1:0] status,
  input logic [ibmw_pkg::WORD_W-1:0]   physical_block,
  input logic [ibmw_pkg::LEN_W-1:0]    read_length
);
  import ibmw_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_address) && $stable(status)
      && $stable(physical_block) && $stable(read_length) && $stable(kind))
    else $error("stalled transaction changed");

  a_request_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_REQUEST) |->
      (status == ST_MAPPED) && (physical_block == '0) && (read_length == '0))
    else $error("request carries answer fields");

  a_mapped: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ANSWER) && (status == ST_MAPPED) |->
      (physical_block != '0) && (read_length != '0) && (read_address == '0))
    else $error("mapped answer malformed");

  a_hole_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_ANSWER) && (status == ST_HOLE) |->
      $onehot(read_length) && (read_length[9:0] == '0) && (physical_block == '0))
    else $error("hole length is not a block size");

endmodule

bind inode_block_map_walker ibmw_checker u_ibmw_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .kind           (result.kind),
  .read_address   (result.read_address),
  .status         (result.status),
  .physical_block (result.physical_block),
  .read_length    (result.read_length)
);

>>> dv/inode_block_map_walker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inode_block_map_walker_test
// Self-checking bench for the inode block map walker. A directed table covers
// reset behaviour, zero pointers, end of file, the clamped block size and the
// ignored commands; random phases then drive mostly complete lookup walks
// (lookup followed by one read reply per indirect level) mixed with table loads
// and stray items, under varying source gaps, sink stalls and a long sink
// hold-off. Results are checked against an in-bench model of the walker or a directed row's listed result.
// ----------------------------------------------------------------------------
module inode_block_map_walker_test;
  import ibmw_pkg::*;

  localparam int TABLE_SLOTS = DIRECT_POINTERS_DEF + INDIRECT_ROOTS;
  localparam int WORDS_LOG_BASE = BASE_LOG - PTR_BYTES_LOG;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 60;

  typedef struct {
    bit               is_cfg;
    logic             reg_idx;
    logic [WORD_W-1:0] reg_val;
    item_t            it;
    bit               typed;
    result_t          want;
  } row_t;

  typedef struct {
    logic [LOG_W-1:0]  bsl;
    logic [WORD_W-1:0] fs;
    int                src;
    int                snk;
    int                n;
    bit                hold;
    bit                pause;
  } phase_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic              cfg_index;
  logic [WORD_W-1:0] cfg_data;

  ibmw_in_if  item_ch ();
  ibmw_out_if result_ch ();

  inode_block_map_walker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // walker model state
  logic [LOG_W-1:0]   size_log;
  logic [WORD_W-1:0]  file_bytes;
  logic [WORD_W-1:0]  ptr_table [TABLE_SLOTS];
  logic [LEVEL_W-1:0] level;
  logic [WORD_W-1:0]  rest_offset;
  logic [LEN_W-1:0]   tail_len;

  result_t due_results [$];
  row_t    plan [$];
  phase_t  phases [$];
  int      errors = 0;
  int      fed = 0;
  int      stall_pct = 0;
  int      hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** inode_block_map_walker: FAILED **");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
  endtask

  function automatic int unsigned eff_log();
    return (size_log > MAX_SIZE_LOG) ? MAX_SIZE_LOG : size_log;
  endfunction

  function automatic longint unsigned block_bytes();
    return 64'd1 << (BASE_LOG + eff_log());
  endfunction

  function automatic result_t mk_result(input logic kind, input logic [ADDR_W-1:0] addr,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [WORD_W-1:0] phys,
                                        input logic [LEN_W-1:0] len);
    result_t r;
    r.kind = kind;
    r.read_address = addr;
    r.status = st;
    r.physical_block = phys;
    r.read_length = len;
    return r;
  endfunction

  function automatic result_t answer(input logic [STATUS_W-1:0] st,
                                     input logic [WORD_W-1:0] phys,
                                     input logic [LEN_W-1:0] len);
    return mk_result(KIND_ANSWER, '0, st, phys, len);
  endfunction

  function automatic item_t itm(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                input logic [WORD_W-1:0] value,
                                input logic [WORD_W-1:0] bidx);
    item_t it;
    it.cmd = cmd;
    it.slot = slot;
    it.value = value;
    it.block_index = bidx;
    return it;
  endfunction

  function automatic result_t issue_request(input logic [WORD_W-1:0] ptr,
                                            input logic [LEVEL_W-1:0] lvl,
                                            input longint unsigned off);
    int unsigned       sh;
    longint unsigned   wi;
    longint unsigned   mask;
    logic [63:0]       addr;
    sh = (int'(lvl) - 1) * (WORDS_LOG_BASE + eff_log());
    wi = off >> sh;
    mask = (64'd1 << sh) - 1;
    level = lvl;
    rest_offset = WORD_W'(off & mask);
    addr = {32'd0, ptr} * block_bytes() + (wi << PTR_BYTES_LOG);
    return mk_result(KIND_REQUEST, addr[ADDR_W-1:0], '0, '0, '0);
  endfunction

  // Returns 1 when the item is acted on, 0 when it is ignored.
  function automatic bit walker_step(input item_t it, output bit has_res,
                                     output result_t res);
    longint unsigned    bs;
    longint unsigned    start;
    longint unsigned    rest;
    longint unsigned    off;
    longint unsigned    cap;
    int unsigned        wl;
    logic [WORD_W-1:0]  p;
    logic [LEVEL_W-1:0] lvl;
    result_t            hole;
    has_res = 1'b0;
    res = '0;
    bs = block_bytes();
    wl = WORDS_LOG_BASE + eff_log();
    hole = answer(ST_HOLE, '0, bs[LEN_W-1:0]);
    case (it.cmd)
      CMD_LOAD: begin
        if (it.slot >= TABLE_SLOTS) return 1'b0;
        ptr_table[it.slot] = it.value;
        return 1'b1;
      end
      CMD_LOOKUP: begin
        if (level != LEVEL_IDLE) return 1'b0;
        has_res = 1'b1;
        start = {32'd0, it.block_index} * bs;
        if (start >= {32'd0, file_bytes}) begin
          res = answer(ST_EOF, '0, '0);
          return 1'b1;
        end
        rest = {32'd0, file_bytes} - start;
        tail_len = (rest < bs) ? rest[LEN_W-1:0] : bs[LEN_W-1:0];
        if (it.block_index < DIRECT_POINTERS_DEF) begin
          p = ptr_table[it.block_index];
          res = (p == '0) ? hole : answer(ST_MAPPED, p, tail_len);
          return 1'b1;
        end
        off = it.block_index - DIRECT_POINTERS_DEF;
        for (int l = 1; l <= INDIRECT_ROOTS; l++) begin
          cap = 64'd1 << (wl * l);
          if (off < cap) begin
            p = ptr_table[DIRECT_POINTERS_DEF + l - 1];
            res = (p == '0) ? hole : issue_request(p, LEVEL_W'(l), off);
            return 1'b1;
          end
          off -= cap;
        end
        res = answer(ST_RANGE, '0, '0);
        return 1'b1;
      end
      CMD_REPLY: begin
        if (level == LEVEL_IDLE) return 1'b0;
        has_res = 1'b1;
        lvl = level;
        level = LEVEL_IDLE;
        if (it.value == '0) res = hole;
        else if (lvl == LEVEL_ONE) res = answer(ST_MAPPED, it.value, tail_len);
        else res = issue_request(it.value, lvl - LEVEL_ONE, {32'd0, rest_offset});
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_index();
    int unsigned wl;
    wl = WORDS_LOG_BASE + eff_log();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, DIRECT_POINTERS_DEF - 1);
      1: return DIRECT_POINTERS_DEF + $urandom_range(0, (1 << wl) - 1);
      2: return DIRECT_POINTERS_DEF + (1 << wl) + ($urandom & ((1 << (2 * wl)) - 1));
      3: return DIRECT_POINTERS_DEF + (1 << wl) + (1 << (2 * wl)) + $urandom_range(0, 1 << 20);
      4: return (file_bytes >> (BASE_LOG + eff_log())) + $urandom_range(0, 2) - 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    return ($urandom_range(0, 7) == 0) ? '0 : $urandom;
  endfunction

  function automatic row_t cfg_row(input logic idx, input logic [WORD_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic row_t item_row(input item_t it, input bit typed, input result_t want);
    row_t r;
    r = '{default: '0};
    r.it = it;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic offer(input item_t it, input bit typed, input result_t want);
    bit      acted;
    bit      has_res;
    result_t res;
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= it.cmd;
    item_ch.slot        <= it.slot;
    item_ch.value       <= it.value;
    item_ch.block_index <= it.block_index;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    acted = walker_step(it, has_res, res);
    if (typed) due_results.push_back(want);
    else if (has_res) due_results.push_back(res);
    if (acted) fed++;
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [WORD_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_BLOCK_SIZE_LOG) size_log = val[LOG_W-1:0];
    else file_bytes = val;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input phase_t ph);
    int r;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    stall_pct = ph.snk;
    fed = 0;
    while (fed < ph.n) begin
      if (ph.hold && !held && fed >= 20) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (ph.pause && !paused && fed >= 60) begin
        paused = 1'b1;
        drain();
      end
      idle_gap(ph.src);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        offer(itm(CMD_LOOKUP, $urandom, $urandom, pick_index()), 1'b0, '0);
        while (level != LEVEL_IDLE) begin
          idle_gap(ph.src);
          r = $urandom_range(0, 99);
          if (r < 8) offer(itm(CMD_LOAD, $urandom, pick_word(), $urandom), 1'b0, '0);
          else if (r < 12) offer(itm(CMD_LOOKUP, $urandom, $urandom, $urandom), 1'b0, '0);
          else offer(itm(CMD_REPLY, $urandom, pick_word(), $urandom), 1'b0, '0);
        end
      end else if (r < 80) begin
        offer(itm(CMD_LOAD, $urandom_range(0, 15), pick_word(), $urandom), 1'b0, '0);
      end else if (r < 88) begin
        offer(itm(CMD_REPLY, $urandom, pick_word(), $urandom), 1'b0, '0);
      end else if (r < 94) begin
        offer(itm(CMD_UNUSED, $urandom, $urandom, $urandom), 1'b0, '0);
      end else begin
        offer(itm(CMD_LOOKUP, $urandom, $urandom, $urandom), 1'b0, '0);
      end
    end
  endtask

  // sink side: random stalls, plus the long hold-off when requested
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = mk_result(result_ch.kind, result_ch.read_address, result_ch.status,
                      result_ch.physical_block, result_ch.read_length);
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result: kind %0d addr %h status %0d phys %h len %0d",
                         got.kind, got.read_address, got.status, got.physical_block,
                         got.read_length));
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.read_address !== want.read_address)
          report($sformatf("read_address %h, expected %h", got.read_address,
                           want.read_address));
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.physical_block !== want.physical_block)
          report($sformatf("physical_block %h, expected %h", got.physical_block,
                           want.physical_block));
        if (got.read_length !== want.read_length)
          report($sformatf("read_length %0d, expected %0d", got.read_length,
                           want.read_length));
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= REG_BLOCK_SIZE_LOG;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.cmd         <= CMD_LOAD;
    item_ch.slot        <= '0;
    item_ch.value       <= '0;
    item_ch.block_index <= '0;
    size_log = '0;
    file_bytes = '0;
    foreach (ptr_table[i]) ptr_table[i] = '0;
    level = LEVEL_IDLE;
    rest_offset = '0;
    tail_len = '0;

    // directed table
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 0), 1, answer(ST_EOF, 0, 0)));
    plan.push_back(item_row(itm(CMD_REPLY, 0, 32'hFFFF_FFFF, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0));
    plan.push_back(cfg_row(REG_FILE_SIZE, 32'hFFFF_FFFF));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 0), 1, answer(ST_HOLE, 0, 17'd1024)));
    plan.push_back(item_row(itm(CMD_LOAD, 0, 32'hFFFF_FFFF, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 0), 1,
                            answer(ST_MAPPED, 32'hFFFF_FFFF, 17'd1024)));
    plan.push_back(item_row(itm(CMD_LOAD, 4'd15, 32'd5, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 12), 1, answer(ST_HOLE, 0, 17'd1024)));
    plan.push_back(item_row(itm(CMD_LOAD, 12, 32'hFFFF_FFFF, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 12), 1,
                            mk_result(KIND_REQUEST, 48'h3FF_FFFF_FC00, '0, '0, '0)));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_REPLY, 0, 0, 0), 1, answer(ST_HOLE, 0, 17'd1024)));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 267), 0, '0));
    plan.push_back(item_row(itm(CMD_REPLY, 0, 32'h0000_ABCD, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOAD, 13, 32'h1234_5678, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOAD, 14, 32'h0000_0100, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 268), 0, '0));
    plan.push_back(item_row(itm(CMD_REPLY, 0, 32'h0000_0022, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_REPLY, 0, 32'h8000_0000, 0), 0, '0));
    plan.push_back(cfg_row(REG_BLOCK_SIZE_LOG, 32'd7));
    plan.push_back(cfg_row(REG_FILE_SIZE, 32'h0002_0064));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 2), 1, answer(ST_HOLE, 0, 17'h10000)));
    plan.push_back(item_row(itm(CMD_LOAD, 2, 32'd7, 0), 0, '0));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 2), 1, answer(ST_MAPPED, 32'd7, 17'd100)));
    plan.push_back(item_row(itm(CMD_LOOKUP, 0, 0, 32'hFFFF_FFFF), 1, answer(ST_EOF, 0, 0)));

    phases.push_back('{3'd0, 32'hFFFF_FFFF, 0, 0, 120, 1'b0, 1'b0});
    phases.push_back('{3'd1, $urandom, 75, 0, 120, 1'b0, 1'b1});
    phases.push_back('{3'd6, 32'hFFFF_FFFF, 0, 75, 120, 1'b1, 1'b0});
    phases.push_back('{3'd3, $urandom, 36, 36, 120, 1'b0, 1'b0});
    phases.push_back('{3'd5, 32'd0, 0, 0, 30, 1'b0, 1'b0});
    phases.push_back('{3'd2, 32'hFFFF_FFFF, 36, 36, 150, 1'b0, 1'b0});
    phases.push_back('{3'd7, $urandom, 0, 0, 90, 1'b0, 1'b0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    foreach (phases[i]) begin
      drain();
      write_reg(REG_BLOCK_SIZE_LOG, {29'd0, phases[i].bsl});
      write_reg(REG_FILE_SIZE, phases[i].fs);
      run_phase(phases[i]);
    end

    drain();
    if (errors == 0) $display("** inode_block_map_walker: PASSED **");
    else $display("** inode_block_map_walker: FAILED **");
    $finish;
  end

endmodule
